// ===== rtl/core/d2a_pkg.sv =====
// ----------------------------------------------------------------------------
// d2a_pkg
// Shared types and constants of the piecewise depth-to-age model core.
// ----------------------------------------------------------------------------
package d2a_pkg;

    localparam int unsigned MAX_SEGMENTS_DEF = 1024;

    localparam int unsigned DEPTH_W   = 32;
    localparam int unsigned RATE_W    = 32;
    localparam int unsigned AGE_W     = 48;
    localparam int unsigned SEG_W     = 10;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 48;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned FRAC_W    = 16;

    localparam logic [DEPTH_W-1:0] SPACING_RESET = 32'h0001_0000;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPACING = 1'b0,
        CFG_TOP_AGE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [DEPTH_W-1:0] segment_depth;
        logic [RATE_W-1:0]  segment_rate;
        logic [DEPTH_W-1:0] query_depth;
    } command_t;

    typedef struct packed {
        logic signed [AGE_W-1:0] age;
        logic [SEG_W-1:0]        segment_found;
        logic                    table_empty;
    } result_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]      breakpoint;
        logic [RATE_W-1:0]       rate;
        logic signed [AGE_W-1:0] prefix;
    } entry_t;

    localparam logic signed [AGE_W-1:0] AGE_MAX = {1'b0, {(AGE_W-1){1'b1}}};
    localparam logic signed [AGE_W-1:0] AGE_MIN = {1'b1, {(AGE_W-1){1'b0}}};

endpackage

// ===== rtl/core/depth_to_age_piecewise_model_core.sv =====
// ----------------------------------------------------------------------------
// depth_to_age_piecewise_model_core
// Segment table with running prefix age and binary-search depth queries.
// ----------------------------------------------------------------------------
// Usage:
//   Commands are transferred on start when busy is low. Clear empties the
//   table in the transfer cycle and leaves busy low. Append writes the
//   entry {depth, rate, prefix} at the transfer edge and stays busy in
//   ST_MUL and ST_ACC while rate * spacing is multiplied and added to the
//   running prefix; an append on a full table is dropped.
//   A query on an empty table answers in the next cycle. Otherwise the
//   query walks the breakpoint memory with one read per cycle in the
//   search state; then ST_LOAD takes rate and offset from the found entry,
//   ST_MUL multiplies them and ST_FINAL subtracts prefix plus product from
//   the top age, with saturation.
//   The registered entry memory read sets this rate: one search step per read.
//   Each result is shown on result for one cycle with done high; the
//   receiver cannot stall. Configuration writes transfer while cfg_ready
//   is high, i.e. while no command is in flight and start is low.
//   Reset clears the table count, running prefix and the registers to
//   spacing 1.0 and top age 0. The entry memory has no reset.
// ----------------------------------------------------------------------------
module depth_to_age_piecewise_model_core #(
    parameter int unsigned MAX_SEGMENTS = d2a_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  d2a_pkg::command_t                    command,
    output logic                                 done,
    output d2a_pkg::result_t                     result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [d2a_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [d2a_pkg::CFG_DAT_W-1:0]        cfg_data
);

    localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned AGE_W = d2a_pkg::AGE_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_LOAD   = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_ACC    = 6'b010000,
        ST_FINAL  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic signed [AGE_W-1:0] running_reg, running_next;
    logic [d2a_pkg::DEPTH_W-1:0] spacing_reg, spacing_next;
    logic signed [AGE_W-1:0] top_age_reg, top_age_next;
    logic done_reg, done_next;
    logic is_query_reg, is_query_next;

    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hp_reg, hp_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [AW-1:0] seg_reg, seg_next;
    logic [d2a_pkg::DEPTH_W-1:0] query_reg, query_next;
    logic [d2a_pkg::RATE_W-1:0] mul_a_reg, mul_a_next;
    logic [d2a_pkg::RATE_W-1:0] mul_b_reg, mul_b_next;
    logic [d2a_pkg::PROD_W-1:0] prod_reg;
    logic neg_reg, neg_next;
    logic signed [AGE_W-1:0] prefix_reg, prefix_next;
    d2a_pkg::result_t result_reg, result_next;

    d2a_pkg::entry_t mem [MAX_SEGMENTS];
    d2a_pkg::entry_t rd_data_reg;
    d2a_pkg::entry_t wr_data;
    logic mem_we;
    logic rd_en;
    logic [AW-1:0] rd_addr;

    logic accept;
    logic full;
    logic [CW-1:0] mid_start;
    logic lt;
    logic [CW-1:0] lo_step, hp_step;
    logic [CW:0] mid_sum;
    logic [CW-1:0] seg_wide;
    logic signed [d2a_pkg::DEPTH_W:0] offset;
    logic [AGE_W-1:0] prod_shift;
    logic signed [AGE_W:0] sprod;
    logic signed [AGE_W+1:0] path_sum;
    logic signed [AGE_W+2:0] age_diff;
    logic signed [AGE_W+1:0] acc_sum;
    logic [d2a_pkg::SEG_W-1:0] seg_found;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign accept    = start && (state_reg == ST_IDLE);
    assign full      = (count_reg == CW'(MAX_SEGMENTS));
    assign mid_start = (count_reg - CW'(1)) >> 1;

    assign lt      = (rd_data_reg.breakpoint < query_reg);
    assign lo_step = lt ? (mid_reg + CW'(1)) : lo_reg;
    assign hp_step = lt ? hp_reg : mid_reg;
    assign mid_sum = {1'b0, lo_step} + {1'b0, hp_step} - (CW + 1)'(1);
    assign seg_wide = (lo_step != '0) ? (lo_step - CW'(1)) : '0;

    assign offset = $signed({1'b0, query_reg}) - $signed({1'b0, rd_data_reg.breakpoint});

    assign prod_shift = prod_reg[d2a_pkg::PROD_W-1:d2a_pkg::FRAC_W];
    assign sprod      = neg_reg ? -$signed({1'b0, prod_shift}) : $signed({1'b0, prod_shift});
    assign path_sum   = (AGE_W + 2)'(prefix_reg) + (AGE_W + 2)'(sprod);
    assign age_diff   = (AGE_W + 3)'(top_age_reg) - (AGE_W + 3)'(path_sum);
    assign acc_sum    = (AGE_W + 2)'(running_reg) + $signed({2'b00, prod_shift});

    for (genvar i = 0; i < d2a_pkg::SEG_W; i++) begin : g_seg
        if (i < AW) begin : g_bit
            assign seg_found[i] = seg_reg[i];
        end
        else begin : g_zero
            assign seg_found[i] = 1'b0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        running_next  = running_reg;
        spacing_next  = spacing_reg;
        top_age_next  = top_age_reg;
        done_next     = 1'b0;
        is_query_next = is_query_reg;
        lo_next       = lo_reg;
        hp_next       = hp_reg;
        mid_next      = mid_reg;
        seg_next      = seg_reg;
        query_next    = query_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        neg_next      = neg_reg;
        prefix_next   = prefix_reg;
        result_next   = result_reg;
        mem_we        = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = mid_start[AW-1:0];
        wr_data.breakpoint = command.segment_depth;
        wr_data.rate       = command.segment_rate;
        wr_data.prefix     = running_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (d2a_pkg::cfg_index_t'(cfg_index))
                d2a_pkg::CFG_SPACING: spacing_next = cfg_data[d2a_pkg::DEPTH_W-1:0];
                d2a_pkg::CFG_TOP_AGE: top_age_next = $signed(cfg_data[AGE_W-1:0]);
                default:              spacing_next = spacing_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    unique case (d2a_pkg::action_t'(command.action))
                        d2a_pkg::ACT_CLEAR:
                        begin
                            count_next   = '0;
                            running_next = '0;
                        end
                        d2a_pkg::ACT_APPEND:
                        begin
                            if (!full) begin
                                mem_we        = 1'b1;
                                count_next    = count_reg + CW'(1);
                                mul_a_next    = command.segment_rate;
                                mul_b_next    = spacing_reg;
                                is_query_next = 1'b0;
                                state_next    = ST_MUL;
                            end
                        end
                        d2a_pkg::ACT_QUERY:
                        begin
                            if (count_reg == '0) begin
                                result_next.age           = top_age_reg;
                                result_next.segment_found = '0;
                                result_next.table_empty   = 1'b1;
                                done_next                 = 1'b1;
                            end
                            else begin
                                rd_en         = 1'b1;
                                lo_next       = '0;
                                hp_next       = count_reg;
                                mid_next      = mid_start;
                                query_next    = command.query_depth;
                                is_query_next = 1'b1;
                                state_next    = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                rd_en   = 1'b1;
                lo_next = lo_step;
                hp_next = hp_step;
                if (lo_step < hp_step) begin
                    mid_next = mid_sum[CW:1];
                    rd_addr  = mid_sum[AW:1];
                end
                else begin
                    seg_next   = seg_wide[AW-1:0];
                    rd_addr    = seg_wide[AW-1:0];
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                neg_next    = offset[d2a_pkg::DEPTH_W];
                mul_a_next  = rd_data_reg.rate;
                mul_b_next  = offset[d2a_pkg::DEPTH_W]
                            ? d2a_pkg::DEPTH_W'(-offset) : offset[d2a_pkg::DEPTH_W-1:0];
                prefix_next = rd_data_reg.prefix;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = is_query_reg ? ST_FINAL : ST_ACC;
            end
            ST_ACC:
            begin
                if (acc_sum > (AGE_W + 2)'(d2a_pkg::AGE_MAX)) begin
                    running_next = d2a_pkg::AGE_MAX;
                end
                else begin
                    running_next = acc_sum[AGE_W-1:0];
                end
                state_next = ST_IDLE;
            end
            ST_FINAL:
            begin
                priority if (age_diff > (AGE_W + 3)'(d2a_pkg::AGE_MAX)) begin
                    result_next.age = d2a_pkg::AGE_MAX;
                end
                else if (age_diff < (AGE_W + 3)'(d2a_pkg::AGE_MIN)) begin
                    result_next.age = d2a_pkg::AGE_MIN;
                end
                else begin
                    result_next.age = age_diff[AGE_W-1:0];
                end
                result_next.segment_found = seg_found;
                result_next.table_empty   = 1'b0;
                done_next                 = 1'b1;
                state_next                = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            running_reg  <= '0;
            spacing_reg  <= d2a_pkg::SPACING_RESET;
            top_age_reg  <= '0;
            done_reg     <= 1'b0;
            is_query_reg <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            running_reg  <= running_next;
            spacing_reg  <= spacing_next;
            top_age_reg  <= top_age_next;
            done_reg     <= done_next;
            is_query_reg <= is_query_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hp_reg     <= hp_next;
        mid_reg    <= mid_next;
        seg_reg    <= seg_next;
        query_reg  <= query_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        prod_reg   <= {{d2a_pkg::RATE_W{1'b0}}, mul_a_reg} * {{d2a_pkg::RATE_W{1'b0}}, mul_b_reg};
        neg_reg    <= neg_next;
        prefix_reg <= prefix_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[count_reg[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/d2a_checker.sv =====
// ----------------------------------------------------------------------------
// d2a_checker
// Port-level checks of the depth-to-age model core, bound to the top level.
// ----------------------------------------------------------------------------
module d2a_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input d2a_pkg::command_t             command,
    input logic                          done,
    input d2a_pkg::result_t              result,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);

    a_no_result_after_other: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command.action != d2a_pkg::ACT_QUERY)) |=> !done)
        else $error("result after a non-query transfer");

    a_empty_seg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_empty) |-> (result.segment_found == '0))
        else $error("empty-table result carries a segment index");

    a_search_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.table_empty) |-> $past(busy))
        else $error("table result without a preceding search");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a command transfer");

    a_cfg_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && busy) |-> !cfg_ready)
        else $error("configuration transfer while a command is in flight");

endmodule

bind depth_to_age_piecewise_model_core d2a_checker u_d2a_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ===== tb/depth_to_age_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_to_age_checker
// Watches the command, configuration and result channels of the depth-to-age
// core. It keeps its own segment table and registers, predicts the result
// of every query transfer, and compares each result field by field with the
// oldest prediction. Leftover predictions are flagged on end_check.
// ----------------------------------------------------------------------------
module depth_to_age_checker #(
    parameter int unsigned MAX_SEGMENTS = d2a_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  d2a_pkg::command_t             command,
    input  logic                          done,
    input  d2a_pkg::result_t              result,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [d2a_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [d2a_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                          end_check,
    output int                            failures,
    output int                            pending_results
);

    localparam int unsigned DEPTH_W = d2a_pkg::DEPTH_W;
    localparam int unsigned RATE_W  = d2a_pkg::RATE_W;
    localparam int unsigned AGE_W   = d2a_pkg::AGE_W;
    localparam int unsigned SEG_W   = d2a_pkg::SEG_W;
    localparam int unsigned FRAC_W  = d2a_pkg::FRAC_W;

    logic [DEPTH_W-1:0]      breakpoint_mem [MAX_SEGMENTS];
    logic [RATE_W-1:0]       rate_mem       [MAX_SEGMENTS];
    logic signed [AGE_W-1:0] prefix_mem     [MAX_SEGMENTS];
    logic signed [AGE_W-1:0] running_age;
    int                      loaded;
    logic [DEPTH_W-1:0]      spacing_reg;
    logic signed [AGE_W-1:0] top_age_reg;

    d2a_pkg::result_t forecast_q [$];
    d2a_pkg::result_t predicted;
    d2a_pkg::result_t oldest;
    bit               leftovers_checked;

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        failures++;
    endtask

    function automatic logic signed [AGE_W-1:0] saturate_age(input longint v);
        longint hi_lim;
        longint lo_lim;
        hi_lim = longint'(d2a_pkg::AGE_MAX);
        lo_lim = longint'(d2a_pkg::AGE_MIN);
        if (v > hi_lim)
            return d2a_pkg::AGE_MAX;
        if (v < lo_lim)
            return d2a_pkg::AGE_MIN;
        return v[AGE_W-1:0];
    endfunction

    function automatic int locate_segment(input logic [DEPTH_W-1:0] depth);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = loaded - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (breakpoint_mem[mid] < depth)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return (lo > 0) ? lo - 1 : 0;
    endfunction

    function automatic bit predict_command(input d2a_pkg::command_t cmd,
                                           output d2a_pkg::result_t r);
        int          seg;
        logic [63:0] step;
        logic [63:0] mag;
        logic [63:0] prod;
        longint      offset;
        longint      signed_prod;
        longint      sum;
        longint      prefix_long;
        longint      top_long;
        r = '0;
        case (d2a_pkg::action_t'(cmd.action))
            d2a_pkg::ACT_CLEAR: begin
                loaded      = 0;
                running_age = '0;
                return 1'b0;
            end
            d2a_pkg::ACT_APPEND: begin
                if (loaded < MAX_SEGMENTS) begin
                    step = ({32'b0, cmd.segment_rate} * {32'b0, spacing_reg}) >> FRAC_W;
                    breakpoint_mem[loaded] = cmd.segment_depth;
                    rate_mem[loaded]       = cmd.segment_rate;
                    prefix_mem[loaded]     = running_age;
                    prefix_long            = longint'(running_age);
                    running_age            = saturate_age(prefix_long + longint'(step));
                    loaded++;
                end
                return 1'b0;
            end
            d2a_pkg::ACT_QUERY: begin
                if (loaded == 0) begin
                    r.age         = top_age_reg;
                    r.table_empty = 1'b1;
                end else begin
                    seg    = locate_segment(cmd.query_depth);
                    offset = longint'({32'b0, cmd.query_depth})
                           - longint'({32'b0, breakpoint_mem[seg]});
                    mag    = (offset < 0) ? -offset : offset;
                    prod   = ({32'b0, rate_mem[seg]} * mag) >> FRAC_W;
                    signed_prod = (offset < 0) ? -longint'(prod) : longint'(prod);
                    prefix_long = longint'(prefix_mem[seg]);
                    top_long    = longint'(top_age_reg);
                    sum         = top_long - (prefix_long + signed_prod);
                    r.age           = saturate_age(sum);
                    r.segment_found = seg[SEG_W-1:0];
                    r.table_empty   = 1'b0;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            loaded            = 0;
            running_age       = '0;
            spacing_reg       = d2a_pkg::SPACING_RESET;
            top_age_reg       = '0;
            failures          = 0;
            leftovers_checked = 1'b0;
            forecast_q.delete();
            pending_results <= 0;
        end else begin
            if (done) begin
                if (forecast_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected, age %0d",
                                              result.age));
                end else begin
                    oldest = forecast_q.pop_front();
                    if (result.age !== oldest.age)
                        report_mismatch($sformatf("age got %0d expected %0d",
                                                  result.age, oldest.age));
                    if (result.segment_found !== oldest.segment_found)
                        report_mismatch($sformatf("segment_found got %0d expected %0d",
                                                  result.segment_found,
                                                  oldest.segment_found));
                    if (result.table_empty !== oldest.table_empty)
                        report_mismatch($sformatf("table_empty got %0b expected %0b",
                                                  result.table_empty, oldest.table_empty));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == d2a_pkg::CFG_SPACING)
                    spacing_reg = cfg_data[DEPTH_W-1:0];
                else
                    top_age_reg = cfg_data;
            end
            if (start && !busy) begin
                if (predict_command(command, predicted))
                    forecast_q.push_back(predicted);
            end
            if (end_check && !leftovers_checked) begin
                foreach (forecast_q[i])
                    report_mismatch($sformatf("missing result, expected age %0d",
                                              forecast_q[i].age));
                leftovers_checked = 1'b1;
            end
            pending_results <= forecast_q.size();
        end
    end

endmodule

// ===== tb/tb_depth_to_age_piecewise_model_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_to_age_piecewise_model_core
// Drives the depth-to-age core with directed corner cases, random segment
// tables with queries and noise commands, under several register settings
// and bursty command timing. A checker beside the core predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_depth_to_age_piecewise_model_core;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 80;
    localparam int unsigned AGE_W = d2a_pkg::AGE_W;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    d2a_pkg::command_t             command;
    logic                          done;
    d2a_pkg::result_t              result;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [d2a_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [d2a_pkg::CFG_DAT_W-1:0] cfg_data;
    logic                          end_check;
    int                            failures;
    int                            pending_results;
    int                            cycle_count = 0;
    int                            burst_left;
    int                            item_count;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    depth_to_age_piecewise_model_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    depth_to_age_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .done            (done),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .end_check       (end_check),
        .failures        (failures),
        .pending_results (pending_results)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input d2a_pkg::action_t act, input logic [31:0] seg_depth,
                             input logic [31:0] seg_rate, input logic [31:0] q_depth);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 5);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start                 <= 1'b1;
        command.action        <= act;
        command.segment_depth <= seg_depth;
        command.segment_rate  <= seg_rate;
        command.query_depth   <= q_depth;
        do @(posedge clk); while (busy);
        if (act != d2a_pkg::ACT_NONE)
            item_count++;
    endtask

    task automatic send_noise();
        send_item(d2a_pkg::action_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (pending_results != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [31:0] spacing,
                                  input logic [AGE_W-1:0] top_age);
        cfg_valid <= 1'b1;
        cfg_index <= d2a_pkg::CFG_SPACING;
        cfg_data  <= {16'b0, spacing};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= d2a_pkg::CFG_TOP_AGE;
        cfg_data  <= top_age;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_rate();
        return ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h3_0000);
    endfunction

    task automatic run_table_sequence();
        logic [31:0] depths [$];
        logic [31:0] depth;
        logic [31:0] pick;
        int unsigned stride;
        int          n;
        int          queries;
        if ($urandom_range(0, 3) != 0)
            send_item(d2a_pkg::ACT_CLEAR, $urandom, $urandom, $urandom);
        n      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        stride = 32'hFFFF_FFFF / (n + 1);
        depth  = $urandom % stride;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            if ($urandom_range(0, 11) == 0) begin
                pick = $urandom;
                depths.push_back(pick);
                send_item(d2a_pkg::ACT_APPEND, pick, pick_rate(), $urandom);
            end else begin
                depths.push_back(depth);
                send_item(d2a_pkg::ACT_APPEND, depth, pick_rate(), $urandom);
                depth = depth + $urandom_range(1, stride);
            end
        end
        queries = $urandom_range(2, 8);
        for (int i = 0; i < queries; i++) begin
            pick = depths[$urandom_range(0, depths.size() - 1)];
            case ($urandom_range(0, 5))
                0: pick = $urandom;
                1: pick = pick;
                2: pick = pick + 1;
                3: pick = pick - 1;
                4: pick = '0;
                default: pick = 32'hFFFF_FFFF;
            endcase
            if ($urandom_range(0, 9) == 0)
                send_noise();
            send_item(d2a_pkg::ACT_QUERY, $urandom, $urandom, pick);
        end
    endtask

    initial begin
        logic [31:0]      spacing;
        logic [AGE_W-1:0] top_age;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        command     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        end_check   <= 1'b0;
        burst_left  = 0;
        item_count  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(d2a_pkg::ACT_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(d2a_pkg::ACT_APPEND, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0);
        send_item(d2a_pkg::ACT_APPEND, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF);
        send_item(d2a_pkg::ACT_APPEND, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_item(d2a_pkg::ACT_QUERY, 32'h0, 32'h0, 32'h0);
        send_item(d2a_pkg::ACT_QUERY, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_item(d2a_pkg::ACT_QUERY, 32'h0, 32'h0, 32'h0001_0000);
        send_item(d2a_pkg::ACT_QUERY, 32'h0, 32'h0, 32'h4000_0000);
        send_item(d2a_pkg::ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(d2a_pkg::ACT_APPEND, 32'h0, 32'h0000_1234, 32'h0);
        send_item(d2a_pkg::ACT_QUERY, 32'h0, 32'h0, 32'h8000_0001);
        send_item(d2a_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(d2a_pkg::ACT_QUERY, 32'h0, 32'h0, 32'h5555_5555);
        settle();

        write_settings(32'hFFFF_FFFF, d2a_pkg::AGE_MIN);
        send_item(d2a_pkg::ACT_APPEND, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_item(d2a_pkg::ACT_APPEND, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0);
        send_item(d2a_pkg::ACT_QUERY, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_item(d2a_pkg::ACT_QUERY, 32'h0, 32'h0, 32'h0);
        settle();

        write_settings(32'h0, d2a_pkg::AGE_MAX);
        send_item(d2a_pkg::ACT_CLEAR, 32'h0, 32'h0, 32'h0);
        send_item(d2a_pkg::ACT_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_item(d2a_pkg::ACT_QUERY, 32'h0, 32'h0, 32'h0);
        settle();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    spacing = $urandom_range(0, 32'h4_0000);
                    top_age = AGE_W'({$urandom, $urandom});
                end
                1: begin
                    spacing = 32'hFFFF_FFFF;
                    top_age = d2a_pkg::AGE_MAX;
                end
                2: begin
                    spacing = 32'h0;
                    top_age = d2a_pkg::AGE_MIN;
                end
                3: begin
                    spacing = d2a_pkg::SPACING_RESET;
                    top_age = '0;
                end
                default: begin
                    spacing = $urandom;
                    top_age = AGE_W'({$urandom, $urandom});
                end
            endcase
            write_settings(spacing, top_age);
            item_count = 0;
            while (item_count < PHASE_ITEMS)
                run_table_sequence();
            settle();
        end

        end_check <= 1'b1;
        @(posedge clk);
        @(posedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
